// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL, included by rrts_datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge out of reset
`define ASSERT_ON(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed: %m");
// expr must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition: %m");
`else
`define ASSERT_ON(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== design/rrts_pkg.sv =====
package rrts_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int ID_W    = 8;
	localparam int LEN_W   = 16;
	localparam int SLICE_W = 16;
	localparam int STAT_W  = 2;
	localparam int ENTRY_W = ID_W + LEN_W;

	localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(1);

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	// sequencer -> datapath
	typedef struct packed {
		logic load_item;  // latch the accepted word
		logic arrive;     // push arrival at queue head, or flag it
		logic rd_head;    // read entry at queue head
		logic take;       // running task <= entry read last cycle
		logic save_old;   // with take: old running task goes to the tail
		logic go_idle;    // finished task, empty queue
		logic count_down; // length and slice countdown
		logic emit;       // load the result register
	} ctrl_cmd_t;

	// datapath -> sequencer
	typedef struct packed {
		logic is_arrival;
		logic busy;
		logic left_zero;
		logic count_nz;
		logic slice_zero;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/rrts_ram.sv =====
module rrts_ram #(
	parameter int WIDTH = rrts_pkg::ENTRY_W,
	parameter int DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/rrts_ctrl.sv =====
module rrts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rrts_pkg::dp_stat_t   stat,
	output rrts_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_ARRIVE = 8'b0000_0010,
		S_P1     = 8'b0000_0100,
		S_TAKE1  = 8'b0000_1000,
		S_P2     = 8'b0001_0000,
		S_TAKE2  = 8'b0010_0000,
		S_DEC    = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_P1;
				end
			end
			// the latched word is visible from here on
			S_P1: begin
				if (stat.is_arrival) begin
					state_d = S_ARRIVE;
				end else if (stat.busy && stat.left_zero) begin
					if (stat.count_nz) begin
						cmd.rd_head = 1'b1;
						state_d     = S_TAKE1;
					end else begin
						cmd.go_idle = 1'b1;
						state_d     = S_P2;
					end
				end else if (!stat.busy && stat.count_nz) begin
					cmd.rd_head = 1'b1;
					state_d     = S_TAKE1;
				end else begin
					state_d = S_P2;
				end
			end
			S_ARRIVE: begin
				cmd.arrive = 1'b1;
				state_d    = S_EMIT;
			end
			S_TAKE1: begin
				cmd.take = 1'b1;
				state_d  = S_P2;
			end
			// slice expiry: rotate at most once per tick
			S_P2: begin
				if (stat.slice_zero && stat.count_nz) begin
					cmd.rd_head = 1'b1;
					state_d     = S_TAKE2;
				end else begin
					state_d = S_DEC;
				end
			end
			S_TAKE2: begin
				cmd.take     = 1'b1;
				cmd.save_old = 1'b1;
				state_d      = S_DEC;
			end
			S_DEC: begin
				cmd.count_down = 1'b1;
				state_d        = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/rrts_datapath.sv =====
`include "assert_macros.svh"

module rrts_datapath #(
	parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rrts_pkg::ctrl_cmd_t          cmd,
	output rrts_pkg::dp_stat_t           stat,
	input  logic                         in_command,
	input  logic [rrts_pkg::ID_W-1:0]    in_id,
	input  logic [rrts_pkg::LEN_W-1:0]   in_len,
	input  logic                         cfg_valid,
	input  logic [rrts_pkg::SLICE_W-1:0] cfg_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         out_run,
	output logic [rrts_pkg::ID_W-1:0]    out_id,
	output logic [rrts_pkg::STAT_W-1:0]  out_status
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;

	localparam int ID_W    = rrts_pkg::ID_W;
	localparam int LEN_W   = rrts_pkg::LEN_W;
	localparam int SLICE_W = rrts_pkg::SLICE_W;
	localparam int STAT_W  = rrts_pkg::STAT_W;
	localparam int ENTRY_W = rrts_pkg::ENTRY_W;

	logic [SLICE_W-1:0] slice_ticks_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic               busy_q;
	logic [ID_W-1:0]    task_q;
	logic [LEN_W-1:0]   left_q;
	logic [SLICE_W-1:0] slice_q;
	logic               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [LEN_W-1:0]   len_q;
	logic [STAT_W-1:0]  status_q;
	logic               out_valid_q;
	logic               out_run_q;
	logic [ID_W-1:0]    out_id_q;
	logic [STAT_W-1:0]  out_status_q;

	logic [AW-1:0]      head_dec;
	logic [AW-1:0]      head_inc;
	logic [SW-1:0]      tail_sum;
	logic [AW-1:0]      tail_addr;
	logic               full;
	logic               arrive_ok;

	logic               ram_wr_en;
	logic [AW-1:0]      ram_wr_addr;
	logic [ENTRY_W-1:0] ram_wr_data;
	logic [ENTRY_W-1:0] ram_rd_data;

	assign head_dec = (head_q == '0) ? AW'(QUEUE_DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);

	// tail slot is head + count, wrapped once
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
	                                                   : AW'(tail_sum);

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign arrive_ok = (len_q != '0) && !full;

	assign ram_wr_en   = (cmd.arrive && arrive_ok) || (cmd.take && cmd.save_old);
	assign ram_wr_addr = cmd.arrive ? head_dec : tail_addr;
	assign ram_wr_data = cmd.arrive ? {len_q, id_q} : {left_q, task_q};

	rrts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (cmd.rd_head),
		.rd_addr (head_q),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_ticks_q <= rrts_pkg::SLICE_RESET;
			head_q        <= '0;
			count_q       <= '0;
			busy_q        <= 1'b0;
			task_q        <= '0;
			left_q        <= '0;
			slice_q       <= '0;
			cmd_q         <= 1'b0;
			status_q      <= rrts_pkg::ST_OK;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				slice_ticks_q <= cfg_data;
			end
			if (cmd.load_item) begin
				cmd_q    <= in_command;
				status_q <= rrts_pkg::ST_OK;
			end
			if (cmd.arrive) begin
				if (len_q == '0) begin
					status_q <= rrts_pkg::ST_INVALID;
				end else if (full) begin
					status_q <= rrts_pkg::ST_FULL;
				end else begin
					head_q  <= head_dec;
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.take) begin
				busy_q  <= 1'b1;
				task_q  <= ram_rd_data[ID_W-1:0];
				left_q  <= ram_rd_data[ENTRY_W-1:ID_W];
				slice_q <= slice_ticks_q;
				head_q  <= head_inc;
				// a rotation pushes one back, count unchanged
				if (!cmd.save_old) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (cmd.go_idle) begin
				busy_q  <= 1'b0;
				task_q  <= '0;
				left_q  <= '0;
				slice_q <= slice_ticks_q;
			end
			if (cmd.count_down) begin
				if (busy_q && left_q != '0) begin
					left_q <= left_q - LEN_W'(1);
				end
				if (slice_q != '0) begin
					slice_q <= slice_q - SLICE_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			id_q  <= in_id;
			len_q <= in_len;
		end
		if (cmd.emit) begin
			out_run_q    <= busy_q;
			out_id_q     <= busy_q ? task_q : '0;
			out_status_q <= status_q;
		end
	end

	always_comb begin
		stat            = '0;
		stat.is_arrival = cmd_q;
		stat.busy       = busy_q;
		stat.left_zero  = (left_q == '0);
		stat.count_nz   = (count_q != '0);
		stat.slice_zero = (slice_q == '0);
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_run    = out_run_q;
	assign out_id     = out_id_q;
	assign out_status = out_status_q;

	`ASSERT_ON(a_count_range, clk, arst_n, count_q <= CW'(QUEUE_DEPTH))
	`ASSERT_ON(a_head_range, clk, arst_n, head_q <= AW'(QUEUE_DEPTH - 1))
	`ASSERT_ON(a_idle_clear, clk, arst_n, busy_q || (task_q == '0 && left_q == '0))
	`ASSERT_ON(a_take_after_read, clk, arst_n, cmd.take |-> $past(cmd.rd_head))
	`ASSERT_NEVER(a_take_empty, clk, arst_n, cmd.take && count_q == '0)

endmodule

// ===== design/round_robin_task_scheduler.sv =====
// Round-robin task scheduler with a programmable time slice. An arrival word
// (tuser = 1) pushes {task_id, task_length} at the head of the ready queue; a
// tick word (tuser = 0) retires a finished task, lets an idle CPU take the
// queue head, rotates the running task to the tail when its slice has run out,
// then counts down the task length and the slice. Each word yields one result
// word with the running task and a status (0 ok, 1 zero-length arrival
// rejected, 2 arrival dropped on a full queue). One word is worked at a time
// by a step sequencer around the queue RAM, whose registered read adds a step
// for each queue pop. The input is not ready again until the result has been
// loaded into the output register, and the sequencer waits to load it while
// the previous result is still held there. A finished result waits in that
// register while the next word is taken. slice_ticks is written over the cfg
// channel, always ready; the user must write it only while the block is idle, which the block does not enforce.
module round_robin_task_scheduler #(
	parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // task_id[7:0], task_length[23:8]
	input  logic [0:0]  s_tuser,   // command[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // running_id[7:0], status[9:8], zero[15:10]
	output logic [0:0]  m_tuser,   // running_valid[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // slice_ticks
);

	rrts_pkg::ctrl_cmd_t cmd;
	rrts_pkg::dp_stat_t  stat;

	logic [rrts_pkg::ID_W-1:0]   out_id;
	logic [rrts_pkg::STAT_W-1:0] out_status;
	logic                        out_run;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrts_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (s_tuser[0]),
		.in_id      (s_tdata[7:0]),
		.in_len     (s_tdata[23:8]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_run    (out_run),
		.out_id     (out_id),
		.out_status (out_status)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {6'b0, out_status, out_id};
	assign m_tuser   = out_run;

endmodule

// ===== tb/sv/rrts_checker.sv =====
`timescale 1ns / 1ps

package rrts_tb_pkg;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_ARRIVE = 1'b1;

endpackage

module rrts_checker
	import rrts_pkg::*;
	import rrts_tb_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // task_id[7:0], task_length[23:8]
	input  logic [0:0]  s_tuser,   // command[0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // running_id[7:0], status[9:8], zero[15:10]
	input  logic [0:0]  m_tuser,   // running_valid[0]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,  // slice_ticks
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
	} task_t;

	typedef struct packed {
		logic              busy;
		logic [ID_W-1:0]   id;
		logic [STAT_W-1:0] status;
	} running_t;

	task_t               ready_q [QUEUE_DEPTH];
	int                  rq_head;
	int                  rq_count;
	logic                cpu_on;
	logic [ID_W-1:0]     cpu_id;
	logic [LEN_W-1:0]    cpu_rem;
	logic [SLICE_W-1:0]  slice_rem;
	logic [SLICE_W-1:0]  slice_len;
	running_t            running_due [$];
	running_t            want;

	initial fail_count = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic void take_head();
		cpu_on   = 1'b1;
		cpu_id   = ready_q[rq_head].id;
		cpu_rem  = ready_q[rq_head].len;
		rq_head  = (rq_head + 1) % QUEUE_DEPTH;
		rq_count--;
	endfunction

	function automatic void advance_tick();
		task_t old;
		if (cpu_on && cpu_rem == '0) begin
			if (rq_count > 0) begin
				take_head();
			end else begin
				cpu_on  = 1'b0;
				cpu_id  = '0;
				cpu_rem = '0;
			end
			// reloaded even when the CPU goes idle
			slice_rem = slice_len;
		end
		if (!cpu_on && rq_count > 0) begin
			take_head();
			slice_rem = slice_len;
		end
		if (slice_rem == '0 && rq_count > 0) begin
			old.id  = cpu_id;
			old.len = cpu_rem;
			take_head();
			ready_q[(rq_head + rq_count) % QUEUE_DEPTH] = old;
			rq_count++;
			slice_rem = slice_len;
		end
		if (cpu_on && cpu_rem != '0)
			cpu_rem--;
		if (slice_rem != '0)
			slice_rem--;
	endfunction

	function automatic running_t schedule_word(input logic cmd, input logic [ID_W-1:0] id,
			input logic [LEN_W-1:0] len);
		running_t r;
		task_t    e;
		r.status = ST_OK;
		if (cmd == CMD_ARRIVE) begin
			// zero length wins over a full queue
			if (len == '0) begin
				r.status = ST_INVALID;
			end else if (rq_count >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				rq_head = (rq_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
				e.id  = id;
				e.len = len;
				ready_q[rq_head] = e;
				rq_count++;
			end
		end else begin
			advance_tick();
		end
		r.busy = cpu_on;
		r.id   = cpu_on ? cpu_id : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_head   = 0;
			rq_count  = 0;
			cpu_on    = 1'b0;
			cpu_id    = '0;
			cpu_rem   = '0;
			slice_rem = '0;
			slice_len = SLICE_RESET;
			running_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				slice_len = cfg_data;
			if (s_tvalid && s_tready)
				running_due.push_back(schedule_word(s_tuser[0], s_tdata[7:0], s_tdata[23:8]));
			if (m_tvalid && m_tready) begin
				if (running_due.size() == 0) begin
					report_mismatch("result word with no task word pending");
				end else begin
					want = running_due.pop_front();
					if (m_tuser[0] !== want.busy)
						report_mismatch($sformatf("running_valid got %0d want %0d",
							m_tuser[0], want.busy));
					if (m_tdata[7:0] !== want.id)
						report_mismatch($sformatf("running_id got %0d want %0d",
							m_tdata[7:0], want.id));
					if (m_tdata[9:8] !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							m_tdata[9:8], want.status));
				end
			end
		end
		pending = running_due.size();
	end

endmodule

// ===== tb/sv/tb_round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
	import rrts_pkg::*;
	import rrts_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 88;
	localparam int PHASES        = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	int src_idle   = 0;
	int sink_stall = 0;
	int fail_count;
	int pending;

	// phase 5 gets a random small slice instead
	logic [15:0] slice_plan [PHASES] = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd5, 16'd7,
		16'd0, 16'd3};

	round_robin_task_scheduler #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	rrts_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_word(input logic cmd, input logic [7:0] id, input logic [15:0] len);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {len, id};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic set_mode(input int m);
		case (m)
			0: begin
				src_idle   <= 0;
				sink_stall <= 0;
			end
			1: begin
				src_idle   <= 67;
				sink_stall <= 0;
			end
			2: begin
				src_idle   <= 0;
				sink_stall <= 67;
			end
			default: begin
				src_idle   <= 23;
				sink_stall <= 23;
			end
		endcase
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only while the block is idle
	task automatic write_slice(input logic [15:0] v);
		s_tvalid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// each burst is at random arrival-heavy (fills the queue) or tick-heavy (drains it);
	// long lengths only when wide, since such tasks never finish within the run
	task automatic run_random(input int n, input bit wide);
		int done = 0;
		int seg;
		int arr_pct;
		int r;
		logic [15:0] len;
		while (done < n) begin
			seg     = $urandom_range(40, 8);
			if (seg > n - done)
				seg = n - done;
			arr_pct = $urandom_range(1) ? 70 : 15;
			repeat (seg) begin
				if ($urandom_range(99) < arr_pct) begin
					r = $urandom_range(99);
					if (r < 8)
						len = '0;
					else if (wide && r < 14)
						len = 16'hFFFF;
					else if (wide && r < 26)
						len = 16'($urandom_range(65535));
					else if (r < 38)
						len = 16'($urandom_range(40, 7));
					else
						len = 16'($urandom_range(6, 1));
					send_word(CMD_ARRIVE, 8'($urandom_range(255)), len);
				end else begin
					send_word(CMD_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)));
				end
				done++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset slice of one: idle CPU, rejects, finish with empty queue, then a full queue
		send_word(CMD_TICK, 8'h00, 16'h0000);
		send_word(CMD_ARRIVE, 8'hFF, 16'h0000);
		send_word(CMD_ARRIVE, 8'h00, 16'h0001);
		send_word(CMD_TICK, 8'h00, 16'h0000);
		send_word(CMD_TICK, 8'hFF, 16'hFFFF);
		send_word(CMD_ARRIVE, 8'hAA, 16'h0002);
		send_word(CMD_ARRIVE, 8'h55, 16'h0003);
		send_word(CMD_TICK, 8'h00, 16'h0000);
		for (int i = 1; i <= 16; i++)
			send_word(CMD_ARRIVE, 8'(i), 16'(i % 5 + 1));
		send_word(CMD_ARRIVE, 8'hFF, 16'h0000);
		send_word(CMD_ARRIVE, 8'h80, 16'hFFFF);
		send_word(CMD_TICK, 8'hFF, 16'hFFFF);

		for (int p = 0; p < PHASES; p++) begin
			write_slice(p == 5 ? 16'($urandom_range(12, 1)) : slice_plan[p]);
			set_mode(p % 4);
			run_random(PHASE_ITEMS, p == PHASES - 1);
		end

		s_tvalid <= 1'b0;
		wait_drained();
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
